// ----- rtl/core/clst_pkg.sv -----
// Package for the C-like source tokenizer: scanner modes, token kinds,
// error kinds, the scanner state record and the token record.
// No dependencies; the scan step and the top level import it.
package clst_pkg;

    localparam int POSITION_BITS = 16;
    localparam int LEN_BITS      = 16;

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
    localparam logic [LEN_BITS-1:0]      LEN_MAX = {LEN_BITS{1'b1}};

    typedef logic [5:0] kind_t;
    typedef logic [2:0] err_t;

    localparam kind_t K_END   = 6'd0;
    localparam kind_t K_ERR   = 6'd1;
    localparam kind_t K_IDENT = 6'd2;
    localparam kind_t K_UNDER = 6'd3;
    localparam kind_t K_NUM   = 6'd4;
    localparam kind_t K_STR   = 6'd5;
    localparam kind_t K_ISTR  = 6'd6;
    localparam kind_t K_CHAR  = 6'd7;

    localparam kind_t OP_ADD        = 6'd8;
    localparam kind_t OP_INC        = 6'd9;
    localparam kind_t OP_ADD_ASSIGN = 6'd10;
    localparam kind_t OP_SUB        = 6'd11;
    localparam kind_t OP_DEC        = 6'd12;
    localparam kind_t OP_ARROW      = 6'd13;
    localparam kind_t OP_SUB_ASSIGN = 6'd14;
    localparam kind_t OP_MUL        = 6'd15;
    localparam kind_t OP_MUL_ASSIGN = 6'd16;
    localparam kind_t OP_DIV        = 6'd17;
    localparam kind_t OP_DIV_ASSIGN = 6'd18;
    localparam kind_t OP_MOD        = 6'd19;
    localparam kind_t OP_MOD_ASSIGN = 6'd20;
    localparam kind_t OP_SEMI       = 6'd21;
    localparam kind_t OP_COMMA      = 6'd22;
    localparam kind_t OP_LPAREN     = 6'd23;
    localparam kind_t OP_RPAREN     = 6'd24;
    localparam kind_t OP_LBRACE     = 6'd25;
    localparam kind_t OP_RBRACE     = 6'd26;
    localparam kind_t OP_LBRACK     = 6'd27;
    localparam kind_t OP_RBRACK     = 6'd28;
    localparam kind_t OP_ASSIGN     = 6'd29;
    localparam kind_t OP_EQ         = 6'd30;
    localparam kind_t OP_FAT_ARROW  = 6'd31;
    localparam kind_t OP_NOT        = 6'd32;
    localparam kind_t OP_NE         = 6'd33;
    localparam kind_t OP_LT         = 6'd34;
    localparam kind_t OP_LE         = 6'd35;
    localparam kind_t OP_SHL        = 6'd36;
    localparam kind_t OP_SHL_ASSIGN = 6'd37;
    localparam kind_t OP_GT         = 6'd38;
    localparam kind_t OP_GE         = 6'd39;
    localparam kind_t OP_SHR        = 6'd40;
    localparam kind_t OP_SHR_ASSIGN = 6'd41;
    localparam kind_t OP_BAND       = 6'd42;
    localparam kind_t OP_LAND       = 6'd43;
    localparam kind_t OP_AND_ASSIGN = 6'd44;
    localparam kind_t OP_BOR        = 6'd45;
    localparam kind_t OP_LOR        = 6'd46;
    localparam kind_t OP_OR_ASSIGN  = 6'd47;
    localparam kind_t OP_XOR        = 6'd48;
    localparam kind_t OP_XOR_ASSIGN = 6'd49;
    localparam kind_t OP_BNOT       = 6'd50;
    localparam kind_t OP_QUEST      = 6'd51;
    localparam kind_t OP_COLON      = 6'd52;
    localparam kind_t OP_SCOPE      = 6'd53;
    localparam kind_t OP_DOT        = 6'd54;
    localparam kind_t OP_ELLIPSIS   = 6'd55;

    localparam err_t E_NONE     = 3'd0;
    localparam err_t E_BADCHAR  = 3'd1;
    localparam err_t E_BADEXP   = 3'd2;
    localparam err_t E_OPENSTR  = 3'd3;
    localparam err_t E_OPENCHAR = 3'd4;
    localparam err_t E_BADESC   = 3'd5;

    // String flag bits
    localparam int F_ESC    = 0;
    localparam int F_BRACE  = 1;
    localparam int F_INTERP = 2;

    typedef enum logic [4:0] {
        M_IDLE, M_IDENT, M_PLUS, M_MINUS, M_STAR, M_SLASH, M_PERCENT, M_EQ,
        M_BANG, M_LT, M_LT2, M_GT, M_GT2, M_AMP, M_PIPE, M_CARET, M_COLON,
        M_DOT1, M_DOT2, M_NINT, M_NDOT, M_NFRAC, M_NE, M_NESIGN, M_NEXP,
        M_LINE, M_BLOCK, M_BSTAR, M_STRING, M_COPEN, M_CESC, M_CCLOSE
    } mode_t;

    typedef struct packed {
        mode_t                    mode;
        logic [POSITION_BITS-1:0] line;
        logic [POSITION_BITS-1:0] col;
        logic [POSITION_BITS-1:0] tok_line;
        logic [POSITION_BITS-1:0] tok_col;
        logic [LEN_BITS-1:0]      len;
        logic [2:0]               flags;
        logic [7:0]               lit;
        logic [7:0]               rbyte;   // held lookahead byte
        logic                     rpend;   // held byte must be rescanned
    } scan_state_t;

    typedef struct packed {
        kind_t       kind;
        err_t        err;
        logic [15:0] line;
        logic [15:0] col;
        logic [15:0] len;
        logic [7:0]  val;
    } token_t;

endpackage

// ----- rtl/core/clst_if.sv -----
// Handshake channels of the tokenizer: source bytes in, tokens out.
// No dependencies.
interface clst_src_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       end_of_source;

    modport source (output valid, source_byte, end_of_source, input ready);
    modport sink   (input valid, source_byte, end_of_source, output ready);
endinterface

interface clst_tok_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [2:0]  error_kind;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [15:0] token_length;
    logic [7:0]  char_value;
    logic        last_of_run;

    modport source (output valid, token_kind, error_kind, start_line, start_column,
                    token_length, char_value, last_of_run, input ready);
    modport sink   (input valid, token_kind, error_kind, start_line, start_column,
                    token_length, char_value, last_of_run, output ready);
endinterface

// ----- rtl/core/clst_scan.sv -----
// One scan step of the tokenizer: applies one byte (or end marker) to the
// scanner state. Depends on clst_pkg.
module clst_scan (
    input  clst_pkg::scan_state_t st,
    input  logic [7:0]            in_byte,
    input  logic                  in_end,
    output clst_pkg::scan_state_t st_next,
    output logic                  emit,
    output clst_pkg::token_t      tok,
    output logic                  take_input
);
    import clst_pkg::*;

    scan_state_t s;
    logic [7:0]  cb;
    logic        ce;
    logic        live;
    logic        ret;
    kind_t       kind;
    err_t        err;
    logic [7:0]  val;
    logic        pk;
    logic        pk_hit;
    kind_t       pk_kind;
    logic [8:0]  esc;

    function automatic logic is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_suffix(logic [7:0] c);
        return c == "f" || c == "F" || c == "d" || c == "D" || c == "q" || c == "Q";
    endfunction

    function automatic scan_state_t take_byte(scan_state_t t, logic [7:0] c);
        scan_state_t r;
        r = t;
        if (c == 8'h0A) begin
            if (r.line != POS_MAX) r.line = r.line + POS_ONE;
            r.col = POS_ONE;
        end else if (r.col != POS_MAX) begin
            r.col = r.col + POS_ONE;
        end
        if (r.len != LEN_MAX) r.len = r.len + LEN_BITS'(1);
        return r;
    endfunction

    function automatic scan_state_t begin_token(scan_state_t t);
        scan_state_t r;
        r = t;
        r.tok_line = t.line;
        r.tok_col  = t.col;
        r.len      = '0;
        r.flags    = '0;
        r.lit      = '0;
        return r;
    endfunction

    function automatic logic [2:0] string_check(logic [2:0] f, logic [7:0] c);
        logic [2:0] r;
        r = f;
        if (f[F_INTERP]) begin
            r = f;
        end else if (f[F_ESC]) begin
            r[F_ESC] = 1'b0;
        end else if (f[F_BRACE] && c != "{") begin
            r = 3'b100;
        end else if (c == "{") begin
            r[F_BRACE] = 1'b1;
        end else if (c == "\\") begin
            r[F_ESC] = 1'b1;
        end
        return r;
    endfunction

    // {known, value}
    function automatic logic [8:0] escape_value(logic [7:0] c);
        logic [8:0] r;
        case (c)
            "n":     r = {1'b1, 8'h0A};
            "t":     r = {1'b1, 8'h09};
            "r":     r = {1'b1, 8'h0D};
            "0":     r = {1'b1, 8'h00};
            "\\":    r = {1'b1, 8'h5C};
            "'":     r = {1'b1, 8'h27};
            "\"":    r = {1'b1, 8'h22};
            default: r = 9'h000;
        endcase
        return r;
    endfunction

    always_comb
    begin
        cb      = st.rpend ? st.rbyte : in_byte;
        ce      = st.rpend ? 1'b0 : in_end;
        live    = !ce;
        s       = st;
        s.rpend = 1'b0;
        ret     = 1'b1;
        emit    = 1'b0;
        kind    = K_END;
        err     = E_NONE;
        val     = '0;
        pk      = 1'b0;
        pk_hit  = 1'b0;
        pk_kind = K_END;
        esc     = escape_value(cb);

        case (st.mode)
            M_IDLE:
            begin
                if (ce) begin
                    s    = begin_token(s);
                    emit = 1'b1;
                    kind = K_END;
                end else if (cb == " " || cb == 8'h09 || cb == 8'h0D || cb == 8'h0A) begin
                    s = take_byte(s, cb);
                end else begin
                    s = begin_token(s);
                    s = take_byte(s, cb);
                    if (is_letter(cb) || cb == "_") begin
                        s.lit  = cb;
                        s.mode = M_IDENT;
                    end else if (is_num(cb)) begin
                        s.mode = M_NINT;
                    end else begin
                        case (cb)
                            "+":  s.mode = M_PLUS;
                            "-":  s.mode = M_MINUS;
                            "*":  s.mode = M_STAR;
                            "/":  s.mode = M_SLASH;
                            "%":  s.mode = M_PERCENT;
                            "=":  s.mode = M_EQ;
                            "!":  s.mode = M_BANG;
                            "<":  s.mode = M_LT;
                            ">":  s.mode = M_GT;
                            "&":  s.mode = M_AMP;
                            "|":  s.mode = M_PIPE;
                            "^":  s.mode = M_CARET;
                            ":":  s.mode = M_COLON;
                            ".":  s.mode = M_DOT1;
                            "\"": s.mode = M_STRING;
                            "'":  s.mode = M_COPEN;
                            ";":  begin emit = 1'b1; kind = OP_SEMI;   end
                            ",":  begin emit = 1'b1; kind = OP_COMMA;  end
                            "(":  begin emit = 1'b1; kind = OP_LPAREN; end
                            ")":  begin emit = 1'b1; kind = OP_RPAREN; end
                            "{":  begin emit = 1'b1; kind = OP_LBRACE; end
                            "}":  begin emit = 1'b1; kind = OP_RBRACE; end
                            "[":  begin emit = 1'b1; kind = OP_LBRACK; end
                            "]":  begin emit = 1'b1; kind = OP_RBRACK; end
                            "~":  begin emit = 1'b1; kind = OP_BNOT;   end
                            "?":  begin emit = 1'b1; kind = OP_QUEST;  end
                            default:
                            begin
                                emit = 1'b1;
                                kind = K_ERR;
                                err  = E_BADCHAR;
                            end
                        endcase
                    end
                end
            end
            M_IDENT:
            begin
                if (live && (is_letter(cb) || is_num(cb) || cb == "_")) begin
                    s = take_byte(s, cb);
                end else begin
                    emit   = 1'b1;
                    kind   = (s.len == LEN_BITS'(1) && s.lit == "_") ? K_UNDER : K_IDENT;
                    s.mode = M_IDLE;
                    ret    = 1'b0;
                end
            end
            M_PLUS:
            begin
                pk = 1'b1;
                if (live && cb == "+")      begin pk_hit = 1'b1; pk_kind = OP_INC; end
                else if (live && cb == "=") begin pk_hit = 1'b1; pk_kind = OP_ADD_ASSIGN; end
                else pk_kind = OP_ADD;
            end
            M_MINUS:
            begin
                pk = 1'b1;
                if (live && cb == "-")      begin pk_hit = 1'b1; pk_kind = OP_DEC; end
                else if (live && cb == ">") begin pk_hit = 1'b1; pk_kind = OP_ARROW; end
                else if (live && cb == "=") begin pk_hit = 1'b1; pk_kind = OP_SUB_ASSIGN; end
                else pk_kind = OP_SUB;
            end
            M_STAR:
            begin
                pk = 1'b1;
                if (live && cb == "=") begin pk_hit = 1'b1; pk_kind = OP_MUL_ASSIGN; end
                else pk_kind = OP_MUL;
            end
            M_SLASH:
            begin
                if (live && (cb == "/" || cb == "*")) begin
                    s      = take_byte(s, cb);
                    s.mode = (cb == "/") ? M_LINE : M_BLOCK;
                end else begin
                    pk = 1'b1;
                    if (live && cb == "=") begin pk_hit = 1'b1; pk_kind = OP_DIV_ASSIGN; end
                    else pk_kind = OP_DIV;
                end
            end
            M_PERCENT:
            begin
                pk = 1'b1;
                if (live && cb == "=") begin pk_hit = 1'b1; pk_kind = OP_MOD_ASSIGN; end
                else pk_kind = OP_MOD;
            end
            M_EQ:
            begin
                pk = 1'b1;
                if (live && cb == "=")      begin pk_hit = 1'b1; pk_kind = OP_EQ; end
                else if (live && cb == ">") begin pk_hit = 1'b1; pk_kind = OP_FAT_ARROW; end
                else pk_kind = OP_ASSIGN;
            end
            M_BANG:
            begin
                pk = 1'b1;
                if (live && cb == "=") begin pk_hit = 1'b1; pk_kind = OP_NE; end
                else pk_kind = OP_NOT;
            end
            M_LT:
            begin
                if (live && cb == "<") begin
                    s      = take_byte(s, cb);
                    s.mode = M_LT2;
                end else begin
                    pk = 1'b1;
                    if (live && cb == "=") begin pk_hit = 1'b1; pk_kind = OP_LE; end
                    else pk_kind = OP_LT;
                end
            end
            M_LT2:
            begin
                pk = 1'b1;
                if (live && cb == "=") begin pk_hit = 1'b1; pk_kind = OP_SHL_ASSIGN; end
                else pk_kind = OP_SHL;
            end
            M_GT:
            begin
                if (live && cb == ">") begin
                    s      = take_byte(s, cb);
                    s.mode = M_GT2;
                end else begin
                    pk = 1'b1;
                    if (live && cb == "=") begin pk_hit = 1'b1; pk_kind = OP_GE; end
                    else pk_kind = OP_GT;
                end
            end
            M_GT2:
            begin
                pk = 1'b1;
                if (live && cb == "=") begin pk_hit = 1'b1; pk_kind = OP_SHR_ASSIGN; end
                else pk_kind = OP_SHR;
            end
            M_AMP:
            begin
                pk = 1'b1;
                if (live && cb == "&")      begin pk_hit = 1'b1; pk_kind = OP_LAND; end
                else if (live && cb == "=") begin pk_hit = 1'b1; pk_kind = OP_AND_ASSIGN; end
                else pk_kind = OP_BAND;
            end
            M_PIPE:
            begin
                pk = 1'b1;
                if (live && cb == "|")      begin pk_hit = 1'b1; pk_kind = OP_LOR; end
                else if (live && cb == "=") begin pk_hit = 1'b1; pk_kind = OP_OR_ASSIGN; end
                else pk_kind = OP_BOR;
            end
            M_CARET:
            begin
                pk = 1'b1;
                if (live && cb == "=") begin pk_hit = 1'b1; pk_kind = OP_XOR_ASSIGN; end
                else pk_kind = OP_XOR;
            end
            M_COLON:
            begin
                pk = 1'b1;
                if (live && cb == ":") begin pk_hit = 1'b1; pk_kind = OP_SCOPE; end
                else pk_kind = OP_COLON;
            end
            M_DOT1:
            begin
                if (live && cb == ".") begin
                    s.rbyte = cb;
                    s.mode  = M_DOT2;
                end else begin
                    emit   = 1'b1;
                    kind   = OP_DOT;
                    s.mode = M_IDLE;
                    ret    = 1'b0;
                end
            end
            M_DOT2:
            begin
                if (live && cb == ".") begin
                    s      = take_byte(s, ".");
                    s      = take_byte(s, cb);
                    emit   = 1'b1;
                    kind   = OP_ELLIPSIS;
                    s.mode = M_IDLE;
                end else begin
                    // emit the first dot, rescan the held dot, then this byte
                    emit    = 1'b1;
                    kind    = OP_DOT;
                    s.mode  = M_IDLE;
                    s.rpend = 1'b1;
                    ret     = 1'b0;
                end
            end
            M_NINT, M_NFRAC, M_NEXP:
            begin
                if (live && is_num(cb)) begin
                    s = take_byte(s, cb);
                end else if (live && cb == "." && st.mode == M_NINT) begin
                    s.rbyte = cb;
                    s.mode  = M_NDOT;
                end else if (live && (cb == "e" || cb == "E") && st.mode != M_NEXP) begin
                    s.rbyte = cb;
                    s.mode  = M_NE;
                end else begin
                    s.mode = M_IDLE;
                    emit   = 1'b1;
                    kind   = K_NUM;
                    if (live && is_suffix(cb)) begin
                        s = take_byte(s, cb);
                    end else begin
                        ret = 1'b0;
                    end
                end
            end
            M_NDOT:
            begin
                if (live && is_num(cb)) begin
                    s      = take_byte(s, ".");
                    s      = take_byte(s, cb);
                    s.mode = M_NFRAC;
                end else begin
                    emit    = 1'b1;
                    kind    = K_NUM;
                    s.mode  = M_IDLE;
                    s.rpend = 1'b1;
                    ret     = 1'b0;
                end
            end
            M_NE:
            begin
                if (live && (is_num(cb) || cb == "+" || cb == "-")) begin
                    s      = take_byte(s, st.rbyte);
                    s      = take_byte(s, cb);
                    s.mode = is_num(cb) ? M_NEXP : M_NESIGN;
                end else begin
                    emit    = 1'b1;
                    kind    = K_NUM;
                    s.mode  = M_IDLE;
                    s.rpend = 1'b1;
                    ret     = 1'b0;
                end
            end
            M_NESIGN:
            begin
                if (live && is_num(cb)) begin
                    s      = take_byte(s, cb);
                    s.mode = M_NEXP;
                end else begin
                    emit   = 1'b1;
                    kind   = K_ERR;
                    err    = E_BADEXP;
                    s.mode = M_IDLE;
                    ret    = 1'b0;
                end
            end
            M_LINE:
            begin
                if (ce || cb == 8'h0A) begin
                    s.mode = M_IDLE;
                    ret    = 1'b0;
                end else begin
                    s = take_byte(s, cb);
                end
            end
            M_BLOCK, M_BSTAR:
            begin
                if (ce) begin
                    s.mode = M_IDLE;
                    ret    = 1'b0;
                end else begin
                    s = take_byte(s, cb);
                    if (st.mode == M_BSTAR && cb == "/") s.mode = M_IDLE;
                    else s.mode = (cb == "*") ? M_BSTAR : M_BLOCK;
                end
            end
            M_STRING:
            begin
                if (ce) begin
                    emit   = 1'b1;
                    kind   = K_ERR;
                    err    = E_OPENSTR;
                    s.mode = M_IDLE;
                    ret    = 1'b0;
                end else begin
                    s.flags = string_check(s.flags, cb);
                    s       = take_byte(s, cb);
                    if (cb == "\"") begin
                        emit   = 1'b1;
                        kind   = s.flags[F_INTERP] ? K_ISTR : K_STR;
                        s.mode = M_IDLE;
                    end
                end
            end
            M_COPEN:
            begin
                if (ce) begin
                    emit   = 1'b1;
                    kind   = K_ERR;
                    err    = E_OPENCHAR;
                    s.mode = M_IDLE;
                    ret    = 1'b0;
                end else begin
                    s = take_byte(s, cb);
                    if (cb == "\\") begin
                        s.mode = M_CESC;
                    end else begin
                        s.lit  = cb;
                        s.mode = M_CCLOSE;
                    end
                end
            end
            M_CESC:
            begin
                if (ce) begin
                    emit   = 1'b1;
                    kind   = K_ERR;
                    err    = E_OPENCHAR;
                    s.mode = M_IDLE;
                    ret    = 1'b0;
                end else begin
                    s = take_byte(s, cb);
                    if (esc[8]) begin
                        s.lit  = esc[7:0];
                        s.mode = M_CCLOSE;
                    end else begin
                        emit   = 1'b1;
                        kind   = K_ERR;
                        err    = E_BADESC;
                        s.mode = M_IDLE;
                    end
                end
            end
            default:
            begin
                // closing quote of a char literal
                if (live && cb == "'") begin
                    s      = take_byte(s, cb);
                    emit   = 1'b1;
                    kind   = K_CHAR;
                    val    = s.lit;
                    s.mode = M_IDLE;
                end else begin
                    emit   = 1'b1;
                    kind   = K_ERR;
                    err    = E_OPENCHAR;
                    s.mode = M_IDLE;
                    ret    = 1'b0;
                end
            end
        endcase

        if (pk) begin
            if (pk_hit) s = take_byte(s, cb);
            emit   = 1'b1;
            kind   = pk_kind;
            s.mode = M_IDLE;
            ret    = pk_hit;
        end

        st_next    = s;
        take_input = ret && !st.rpend;
        tok.kind   = kind;
        tok.err    = err;
        tok.line   = 16'(s.tok_line);
        tok.col    = 16'(s.tok_col);
        tok.len    = 16'(s.len);
        tok.val    = val;
    end

endmodule

// ----- rtl/core/c_like_source_tokenizer_unit.sv -----
// Top level of the C-like source tokenizer: input register, scan step,
// pending-token register and output register. Depends on clst_pkg,
// clst_if (channels) and clst_scan.

// Source bytes enter on src, one transaction per byte (or one end marker),
// and tokens leave on tok, one transaction per token, with last_of_run set
// on the final token caused by an input transaction. A single scan unit does
// one step per cycle between the input register and the token registers
// while no parked final token or busy output register holds it, and then
// the block takes a new ordinary byte every cycle. A byte that ends a
// pending token is scanned again in a further step; where a held lookahead
// byte ("." or "e") is pending, it is rescanned first in a step of its own.
// When the last token of an input lands behind another token (two or more
// tokens from one input, or a busy output register), it is parked in the
// pending register and released before the next scan. Lines and columns
// start at 1 and saturate; keywords come out as identifiers. After the end
// token the scanner is idle again and keeps its position, so later bytes
// continue the numbering.
module c_like_source_tokenizer_unit (
    input  logic              clk,
    input  logic              rst_n,
    clst_src_if.sink          src,
    clst_tok_if.source        tok
);
    import clst_pkg::*;

    localparam scan_state_t ST_RESET = '{
        mode: M_IDLE, line: POS_ONE, col: POS_ONE, tok_line: POS_ONE, tok_col: POS_ONE,
        len: '0, flags: '0, lit: '0, rbyte: '0, rpend: 1'b0};

    scan_state_t st_reg;
    scan_state_t st_next;
    scan_state_t step_st;

    logic        in_v_reg;
    logic        in_v_next;
    logic [7:0]  in_byte_reg;
    logic        in_end_reg;

    logic        pend_v_reg;
    logic        pend_v_next;
    logic        pend_final_reg;
    logic        pend_final_next;
    token_t      pend_tok_reg;
    token_t      pend_tok_next;

    logic        out_v_reg;
    logic        out_v_next;
    logic        out_last_reg;
    logic        out_last_next;
    token_t      out_tok_reg;
    token_t      out_tok_next;

    logic        emit;
    token_t      step_tok;
    logic        take_input;
    logic        out_free;
    logic        flush;
    logic        need_out;
    logic        step;
    logic        accept;

    clst_scan u_scan (
        .st         (st_reg),
        .in_byte    (in_byte_reg),
        .in_end     (in_end_reg),
        .st_next    (step_st),
        .emit       (emit),
        .tok        (step_tok),
        .take_input (take_input)
    );

    // A final token parked in the pending register goes out before any
    // further scanning.
    assign out_free = !out_v_reg || tok.ready;
    assign flush    = pend_v_reg && pend_final_reg;
    assign need_out = pend_v_reg && (emit || take_input);
    assign step     = in_v_reg && !flush && (!need_out || out_free);
    assign src.ready = !in_v_reg || (step && take_input);
    assign accept   = src.valid && src.ready;

    always_comb
    begin
        st_next         = step ? step_st : st_reg;
        in_v_next       = in_v_reg;
        pend_v_next     = pend_v_reg;
        pend_final_next = pend_final_reg;
        pend_tok_next   = pend_tok_reg;
        out_v_next      = out_v_reg && !tok.ready;
        out_last_next   = out_last_reg;
        out_tok_next    = out_tok_reg;

        if (step && take_input) in_v_next = 1'b0;
        if (accept) in_v_next = 1'b1;

        if (flush && out_free) begin
            out_v_next    = 1'b1;
            out_tok_next  = pend_tok_reg;
            out_last_next = 1'b1;
            pend_v_next   = 1'b0;
        end else if (step) begin
            if (emit) begin
                if (pend_v_reg) begin
                    // older token is known not to be last
                    out_v_next      = 1'b1;
                    out_tok_next    = pend_tok_reg;
                    out_last_next   = 1'b0;
                    pend_v_next     = 1'b1;
                    pend_final_next = take_input;
                    pend_tok_next   = step_tok;
                end else if (take_input && out_free) begin
                    out_v_next    = 1'b1;
                    out_tok_next  = step_tok;
                    out_last_next = 1'b1;
                end else begin
                    pend_v_next     = 1'b1;
                    pend_final_next = take_input;
                    pend_tok_next   = step_tok;
                end
            end else if (take_input && pend_v_reg) begin
                out_v_next    = 1'b1;
                out_tok_next  = pend_tok_reg;
                out_last_next = 1'b1;
                pend_v_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg          <= ST_RESET;
            in_v_reg        <= 1'b0;
            pend_v_reg      <= 1'b0;
            pend_final_reg  <= 1'b0;
            out_v_reg       <= 1'b0;
        end else begin
            st_reg          <= st_next;
            in_v_reg        <= in_v_next;
            pend_v_reg      <= pend_v_next;
            pend_final_reg  <= pend_final_next;
            out_v_reg       <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            in_byte_reg <= src.source_byte;
            in_end_reg  <= src.end_of_source;
        end
        pend_tok_reg <= pend_tok_next;
        out_tok_reg  <= out_tok_next;
        out_last_reg <= out_last_next;
    end

    assign tok.valid        = out_v_reg;
    assign tok.token_kind   = out_tok_reg.kind;
    assign tok.error_kind   = out_tok_reg.err;
    assign tok.start_line   = out_tok_reg.line;
    assign tok.start_column = out_tok_reg.col;
    assign tok.token_length = out_tok_reg.len;
    assign tok.char_value   = out_tok_reg.val;
    assign tok.last_of_run  = out_last_reg;

    // A held byte is only rescanned while its input is still in hand.
    a_replay_has_input: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.rpend |-> in_v_reg)
        else $error("replay pending without input");

    // Rescanning a held byte never retires the input transaction.
    a_replay_keeps_input: assert property (@(posedge clk) disable iff (!rst_n)
        (step && st_reg.rpend) |-> !take_input)
        else $error("replay step consumed input");

    // A token not marked last always has a successor waiting behind it.
    a_not_last_has_next: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !out_last_reg) |-> pend_v_reg)
        else $error("non-final token without successor");

    // A final parked token blocks new input until it is released.
    a_flush_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (flush && in_v_reg) |-> !src.ready)
        else $error("input taken during flush");

endmodule
